### rtl/jgm_pkg.sv
package jgm_pkg;

  // sizes fixed by the item formats
  localparam int POS_W      = 16;
  localparam int RADIUS_W   = 12;
  localparam int ID_OUT_W   = 6;
  localparam int CNT_OUT_W  = 7;

  localparam int MAX_JUNCTIONS_DEF = 64;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd300;

  // heading arithmetic, two bits wrap around the compass
  localparam logic [1:0] TURN_RIGHT_STEP = 2'd1;
  localparam logic [1:0] TURN_LEFT_STEP  = 2'd3;
  localparam logic [1:0] HEAD_REVERSE    = 2'd2;
  localparam logic [1:0] HEAD_FRONT      = 2'd0;

  typedef enum logic [1:0] {
    KIND_SENSE  = 2'd0,
    KIND_TURN_R = 2'd1,
    KIND_TURN_L = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [POS_W-1:0]   pos_x_mm;
    logic signed [POS_W-1:0]   pos_y_mm;
    logic                      wall_front;
    logic                      wall_right;
    logic                      wall_left;
    logic [ID_OUT_W-1:0]       query_junction;
    logic [1:0]                query_heading;
  } in_item_t;

  typedef struct packed {
    logic                      at_junction;
    logic                      linked;
    logic                      was_repeat;
    logic                      table_full;
    logic [ID_OUT_W-1:0]       current_id;
    logic [1:0]                heading;
    logic                      edge_valid;
    logic [ID_OUT_W-1:0]       edge_target;
    logic signed [POS_W-1:0]   junction_x_mm;
    logic signed [POS_W-1:0]   junction_y_mm;
    logic [CNT_OUT_W-1:0]      junction_count;
  } out_item_t;

endpackage

### rtl/junction_graph_mapper.sv
// sense item at a junction: the result follows a check against the last junction and, on a
//   miss, a scan of the stored junctions by the distance unit, one stored pose per cycle
// read items: result shown after the S_READ state; turn and plain sense items: shown the cycle after accept
// next item may be accepted in the cycle its result is shown; results cannot be stalled
// synchronous reset, then a clearing pass over all 4*MAX_JUNCTIONS edge table entries
//   (256 by default) with busy high; cfg writes are taken during it
module junction_graph_mapper #(
  parameter int MAX_JUNCTIONS = jgm_pkg::MAX_JUNCTIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  jgm_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  output jgm_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [jgm_pkg::RADIUS_W-1:0]      cfg_wdata
);

  localparam int POS_W   = jgm_pkg::POS_W;
  localparam int RAD_W   = jgm_pkg::RADIUS_W;
  localparam int OID_W   = jgm_pkg::ID_OUT_W;
  localparam int OCNT_W  = jgm_pkg::CNT_OUT_W;
  localparam int ID_W    = $clog2(MAX_JUNCTIONS);
  localparam int CNT_W   = $clog2(MAX_JUNCTIONS + 1);
  localparam int EA_W    = ID_W + 2;
  localparam int E_DEPTH = 4 * MAX_JUNCTIONS;
  localparam int CMP_W   = (CNT_W > OID_W) ? CNT_W : OID_W;
  localparam int SQ_W    = 2 * POS_W;
  localparam int R2_W    = 2 * RAD_W;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_JUNCTIONS);

  typedef logic [ID_W-1:0] id_t;

  typedef struct packed {
    logic valid;
    id_t  target;
  } edge_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
  } pose_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LAST,
    S_LWAIT,
    S_SCAN,
    S_LINK1,
    S_LINK2,
    S_READ
  } state_t;

  // sequencer state
  state_t           state_r;
  logic [EA_W-1:0]  clr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_r;
  id_t              cur_r;
  id_t              tgt_r;
  logic [1:0]       head_r;
  logic             found_r;
  logic             qok_r;
  pose_t            last_r;
  pose_t            item_pos_r;

  // result registers
  logic             out_valid_r;
  logic             at_r;
  logic             linked_r;
  logic             rep_r;
  logic             full_r;
  logic             ev_r;
  id_t              et_r;
  pose_t            qpose_r;

  // match radius and its square
  logic [RAD_W-1:0] radius_r;
  logic [R2_W-1:0]  r2_r;

  // junction pose store and edge table
  pose_t            pose_mem [MAX_JUNCTIONS];
  edge_t            edge_mem [E_DEPTH];
  pose_t            pose_rd_r;
  edge_t            edge_rd_r;

  // distance unit pipeline: read, square, compare
  logic             rd_vld_r;
  id_t              rd_idx_r;
  logic             vld1_r;
  id_t              idx1_r;
  logic [SQ_W-1:0]  sqx_r;
  logic [SQ_W-1:0]  sqy_r;
  logic             vld2_r;
  id_t              idx2_r;
  logic             hit_r;

  logic             accept;
  logic             in_at;
  logic             issue;
  logic             qok;
  id_t              last_idx;
  id_t              pose_raddr;
  logic [EA_W-1:0]  edge_raddr;
  logic             pose_we;
  id_t              pose_waddr;
  pose_t            pose_wdata;
  logic             edge_we;
  logic [EA_W-1:0]  edge_waddr;
  edge_t            edge_wdata;

  logic             u_vld;
  pose_t            u_b;
  logic signed [POS_W:0]     dx;
  logic signed [POS_W:0]     dy;
  logic signed [2*POS_W+1:0] prodx;
  logic signed [2*POS_W+1:0] prody;
  logic [SQ_W-1:0]  sqx_nxt;
  logic [SQ_W-1:0]  sqy_nxt;
  logic [SQ_W:0]    dist2;
  logic             hit_nxt;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // a junction shows as a side opening or a wall ahead
  assign in_at = !in_data.wall_right || !in_data.wall_left || in_data.wall_front;

  // issue one stored pose per cycle until every stored junction has gone in
  assign issue    = (state_r == S_SCAN) && (scan_r != count_r);
  assign last_idx = ID_W'(count_r - CNT_W'(1));
  assign qok      = CMP_W'(in_data.query_junction) < CMP_W'(count_r);

  // read addresses: pose scan index while searching, else the queried junction; edge always the queried one
  assign pose_raddr = issue ? scan_r[ID_W-1:0] : ID_W'(in_data.query_junction);
  assign edge_raddr = {ID_W'(in_data.query_junction), in_data.query_heading};

  // pose writes: entry 0 zeroed by the clearing pass, new junctions on append
  always_comb begin
    pose_we    = 1'b0;
    pose_waddr = tgt_r;
    pose_wdata = item_pos_r;
    if (state_r == S_CLEAR) begin
      pose_we    = (clr_r == '0);
      pose_waddr = '0;
      pose_wdata = '0;
    end else if (state_r == S_LINK1) begin
      pose_we    = !found_r;
    end
  end

  // edge writes: clearing pass, forward link, then reverse link
  always_comb begin
    edge_we    = 1'b0;
    edge_waddr = clr_r;
    edge_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_r;
        // junction 0 front leads to junction 1 from the start
        edge_wdata = (clr_r == {cur_r, jgm_pkg::HEAD_FRONT} && clr_r == '0) ?
                     edge_t'{valid: 1'b1, target: id_t'(1)} : '0;
      end
      S_LINK1: begin
        edge_we    = 1'b1;
        edge_waddr = {cur_r, head_r};
        edge_wdata = edge_t'{valid: 1'b1, target: tgt_r};
      end
      S_LINK2: begin
        edge_we    = 1'b1;
        edge_waddr = {tgt_r, head_r + jgm_pkg::HEAD_REVERSE};
        edge_wdata = edge_t'{valid: 1'b1, target: cur_r};
      end
      default: begin
        edge_we    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pose_we) begin
      pose_mem[pose_waddr] <= pose_wdata;
    end
    pose_rd_r <= pose_mem[pose_raddr];
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    edge_rd_r <= edge_mem[edge_raddr];
  end

  // distance unit: the item position against the last junction or a stored pose
  assign u_vld   = (state_r == S_LAST) || rd_vld_r;
  assign u_b     = (state_r == S_LAST) ? last_r : pose_rd_r;
  assign dx      = {item_pos_r.x[POS_W-1], item_pos_r.x} - {u_b.x[POS_W-1], u_b.x};
  assign dy      = {item_pos_r.y[POS_W-1], item_pos_r.y} - {u_b.y[POS_W-1], u_b.y};
  assign prodx   = dx * dx;
  assign prody   = dy * dy;
  // a 17-bit difference squared stays below 2^32
  assign sqx_nxt = prodx[SQ_W-1:0];
  assign sqy_nxt = prody[SQ_W-1:0];
  assign dist2   = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign hit_nxt = dist2 < (SQ_W+1)'(r2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      vld1_r   <= 1'b0;
      vld2_r   <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      vld1_r   <= u_vld;
      vld2_r   <= vld1_r;
    end
    rd_idx_r <= scan_r[ID_W-1:0];
    idx1_r   <= rd_idx_r;
    sqx_r    <= sqx_nxt;
    sqy_r    <= sqy_nxt;
    idx2_r   <= idx1_r;
    hit_r    <= hit_nxt;
  end

  // radius register, squared for the compare
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= jgm_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
    r2_r <= radius_r * radius_r;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      count_r     <= CNT_W'(1);
      cur_r       <= '0;
      head_r      <= jgm_pkg::HEAD_FRONT;
      last_r      <= '0;
      scan_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + EA_W'(1);
          if (clr_r == EA_W'(E_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_pos_r <= pose_t'{x: in_data.pos_x_mm, y: in_data.pos_y_mm};
            qok_r      <= qok;
            scan_r     <= '0;
            at_r       <= 1'b0;
            linked_r   <= 1'b0;
            rep_r      <= 1'b0;
            full_r     <= 1'b0;
            ev_r       <= 1'b0;
            et_r       <= '0;
            qpose_r    <= '0;
            case (in_data.kind)
              jgm_pkg::KIND_SENSE: begin
                at_r <= in_at;
                if (in_at) begin
                  state_r <= S_LAST;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              jgm_pkg::KIND_TURN_R: begin
                head_r      <= head_r + jgm_pkg::TURN_RIGHT_STEP;
                out_valid_r <= 1'b1;
              end
              jgm_pkg::KIND_TURN_L: begin
                head_r      <= head_r + jgm_pkg::TURN_LEFT_STEP;
                out_valid_r <= 1'b1;
              end
              default: begin
                // read: memory data arrives next cycle
                state_r <= S_READ;
              end
            endcase
          end
        end
        S_LAST: begin
          state_r <= S_LWAIT;
        end
        S_LWAIT: begin
          if (vld2_r) begin
            if (hit_r) begin
              // still inside the last junction
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            scan_r <= scan_r + CNT_W'(1);
          end
          if (vld2_r) begin
            if (hit_r) begin
              // lowest id wins, results come back in scan order
              tgt_r   <= idx2_r;
              found_r <= 1'b1;
              state_r <= S_LINK1;
            end else if (idx2_r == last_idx) begin
              found_r <= 1'b0;
              if (count_r == CNT_MAX) begin
                full_r      <= 1'b1;
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                tgt_r   <= count_r[ID_W-1:0];
                state_r <= S_LINK1;
              end
            end
          end
        end
        S_LINK1: begin
          if (!found_r) begin
            count_r <= count_r + CNT_W'(1);
          end
          state_r <= S_LINK2;
        end
        S_LINK2: begin
          cur_r       <= tgt_r;
          last_r      <= item_pos_r;
          linked_r    <= 1'b1;
          rep_r       <= found_r;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_READ: begin
          ev_r        <= qok_r && edge_rd_r.valid;
          et_r        <= (qok_r && edge_rd_r.valid) ? edge_rd_r.target : '0;
          qpose_r     <= qok_r ? pose_rd_r : '0;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result fields, current state is already the state after the item
  assign out_valid                = out_valid_r;
  assign out_data.at_junction     = at_r;
  assign out_data.linked          = linked_r;
  assign out_data.was_repeat      = rep_r;
  assign out_data.table_full      = full_r;
  assign out_data.current_id      = OID_W'(cur_r);
  assign out_data.heading         = head_r;
  assign out_data.edge_valid      = ev_r;
  assign out_data.edge_target     = OID_W'(et_r);
  assign out_data.junction_x_mm   = qpose_r.x;
  assign out_data.junction_y_mm   = qpose_r.y;
  assign out_data.junction_count  = OCNT_W'(count_r);

`ifndef SYNTHESIS
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy)
    else $error("result shown while sequencer busy");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= CNT_W'(1)) && (count_r <= CNT_MAX))
    else $error("junction count out of range");

  a_cur_stored: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(cur_r) < count_r)
    else $error("current junction not stored");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r != $past(count_r))) |->
      (($past(state_r) == S_LINK1) && (count_r == $past(count_r) + CNT_W'(1))))
    else $error("junction count changed outside append");
`endif

endmodule

### tb/sv/tb.sv
module tb;

  localparam int DEPTH      = jgm_pkg::MAX_JUNCTIONS_DEF;
  localparam int POS_W      = jgm_pkg::POS_W;
  localparam int ID_W       = jgm_pkg::ID_OUT_W;
  localparam int CNT_W      = jgm_pkg::CNT_OUT_W;
  localparam int RAD_W      = jgm_pkg::RADIUS_W;
  localparam int IN_W       = $bits(jgm_pkg::in_item_t);
  localparam int GRID_MM    = 1500;
  localparam int LIMIT      = 1000000;
  localparam int DRAIN_WAIT = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  jgm_pkg::in_item_t in_data = '0;
  logic out_valid;
  jgm_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [RAD_W-1:0] cfg_wdata = '0;

  junction_graph_mapper dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // mirror of the junction map kept by the testbench
  logic signed [POS_W-1:0] pose_x [DEPTH];
  logic signed [POS_W-1:0] pose_y [DEPTH];
  logic link_ok [DEPTH][4];
  logic [ID_W-1:0] link_to [DEPTH][4];
  int unsigned stored;
  logic [ID_W-1:0] here_id;
  logic [1:0] facing;
  logic signed [POS_W-1:0] last_x, last_y;
  int unsigned radius_mm;

  jgm_pkg::in_item_t pending_items [$];
  jgm_pkg::out_item_t awaited_reports [$];
  jgm_pkg::out_item_t want;

  int mismatches = 0;
  int cycles = 0;
  bit feeding = 1'b0;
  bit steady = 1'b0;
  bit taken = 1'b0;
  int gx = 0, gy = 0;

  // squared distance test, no root
  function automatic bit near(logic signed [POS_W-1:0] ax, logic signed [POS_W-1:0] ay,
                              logic signed [POS_W-1:0] bx, logic signed [POS_W-1:0] by);
    longint dx, dy, r;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    r = longint'(radius_mm);
    return dx * dx + dy * dy < r * r;
  endfunction

  // applies one item to the mirrored map and returns the report it should produce
  function automatic jgm_pkg::out_item_t map_junction_item(jgm_pkg::in_item_t it);
    jgm_pkg::out_item_t rep;
    logic [ID_W-1:0] tgt;
    bit hit;
    rep = '0;
    tgt = '0;
    hit = 1'b0;
    case (it.kind)
      jgm_pkg::KIND_SENSE: begin
        rep.at_junction = !it.wall_right || !it.wall_left || it.wall_front;
        if (rep.at_junction && !near(it.pos_x_mm, it.pos_y_mm, last_x, last_y)) begin
          // lowest id within the radius wins
          for (int i = 0; i < DEPTH; i++) begin
            if (!hit && i < stored && near(it.pos_x_mm, it.pos_y_mm, pose_x[i], pose_y[i])) begin
              tgt = ID_W'(i);
              hit = 1'b1;
            end
          end
          if (hit) begin
            rep.was_repeat = 1'b1;
          end else if (stored < DEPTH) begin
            tgt = ID_W'(stored);
            pose_x[tgt] = it.pos_x_mm;
            pose_y[tgt] = it.pos_y_mm;
            stored++;
          end else begin
            rep.table_full = 1'b1;
          end
          if (!rep.table_full) begin
            last_x = it.pos_x_mm;
            last_y = it.pos_y_mm;
            // forward link first, reverse link last so a self match keeps it
            link_ok[here_id][facing] = 1'b1;
            link_to[here_id][facing] = tgt;
            link_ok[tgt][facing + jgm_pkg::HEAD_REVERSE] = 1'b1;
            link_to[tgt][facing + jgm_pkg::HEAD_REVERSE] = here_id;
            here_id = tgt;
            rep.linked = 1'b1;
          end
        end
      end
      jgm_pkg::KIND_TURN_R: facing = facing + jgm_pkg::TURN_RIGHT_STEP;
      jgm_pkg::KIND_TURN_L: facing = facing + jgm_pkg::TURN_LEFT_STEP;
      default: begin
        // queries past the stored junctions read as all zero
        if (it.query_junction < stored) begin
          rep.edge_valid = link_ok[it.query_junction][it.query_heading];
          rep.edge_target = rep.edge_valid ? link_to[it.query_junction][it.query_heading] : '0;
          rep.junction_x_mm = pose_x[it.query_junction];
          rep.junction_y_mm = pose_y[it.query_junction];
        end
      end
    endcase
    rep.current_id = here_id;
    rep.heading = facing;
    rep.junction_count = CNT_W'(stored);
    return rep;
  endfunction

  // fully random item, every field random
  function automatic jgm_pkg::in_item_t random_item();
    return jgm_pkg::in_item_t'(IN_W'({$urandom, $urandom}));
  endfunction

  // item builders, fields that the kind ignores are left random
  function automatic jgm_pkg::in_item_t sense_item(int x, int y, logic [2:0] walls);
    jgm_pkg::in_item_t it;
    it = random_item();
    it.kind = jgm_pkg::KIND_SENSE;
    it.pos_x_mm = 16'(x);
    it.pos_y_mm = 16'(y);
    {it.wall_front, it.wall_right, it.wall_left} = walls;
    return it;
  endfunction

  function automatic jgm_pkg::in_item_t read_item(int q, logic [1:0] h);
    jgm_pkg::in_item_t it;
    it = random_item();
    it.kind = jgm_pkg::KIND_READ;
    it.query_junction = ID_W'(q);
    it.query_heading = h;
    return it;
  endfunction

  function automatic jgm_pkg::in_item_t turn_item(jgm_pkg::kind_t k);
    jgm_pkg::in_item_t it;
    it = random_item();
    it.kind = k;
    return it;
  endfunction

  // robot walk over a square grid of junction sites with jitter of up to jit in each axis
  task automatic queue_walk(int n, int span, int jit);
    int r, w;
    jgm_pkg::in_item_t it;
    if (gx >= span) gx = span - 1;
    if (gy >= span) gy = span - 1;
    for (int c = 0; c < n; c++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        it = random_item();
      end else if (r < 35) begin
        it = $urandom_range(0, 1) ? turn_item(jgm_pkg::KIND_TURN_R)
                                  : turn_item(jgm_pkg::KIND_TURN_L);
      end else if (r < 50) begin
        it = read_item(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12),
                       2'($urandom_range(0, 3)));
      end else begin
        // mostly step to a neighbor site, sometimes stay put
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1)) begin
            if ($urandom_range(0, 1)) gx = (gx + 1 < span) ? gx + 1 : gx - 1;
            else gx = (gx > 0) ? gx - 1 : gx + 1;
          end else begin
            if ($urandom_range(0, 1)) gy = (gy + 1 < span) ? gy + 1 : gy - 1;
            else gy = (gy > 0) ? gy - 1 : gy + 1;
          end
        end
        // wall pattern: mostly a junction, front-only-open corridor otherwise
        if ($urandom_range(0, 99) < 15) begin
          w = 3;
        end else begin
          w = $urandom_range(0, 6);
          if (w >= 3) w++;
        end
        it = sense_item((gx - span / 2) * GRID_MM + int'($urandom_range(0, 2 * jit)) - jit,
                        (gy - span / 2) * GRID_MM + int'($urandom_range(0, 2 * jit)) - jit,
                        3'(w));
      end
      pending_items.push_back(it);
    end
  endtask

  // nothing queued, nothing on the port, nothing outstanding
  task automatic wait_quiet();
    while (pending_items.size() != 0 || start || awaited_reports.size() != 0) @(posedge clk);
  endtask

  task automatic set_radius(int unsigned v);
    wait_quiet();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= RAD_W'(v);
    radius_mm = v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver: presents queued items at the falling edge, holds until accepted
  always @(negedge clk) begin
    if (!feeding) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      start <= 1'b1;
    end else if (pending_items.size() != 0 && (steady || $urandom_range(0, 99) >= 14)) begin
      start <= 1'b1;
      in_data <= pending_items.pop_front();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check the report strobe, then predict for an item taken at this edge
  always @(posedge clk) begin
    taken <= start && !busy;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_reports.size() == 0) begin
          $display("%0t: unexpected report, expected none, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (out_data !== want) begin
            $display("%0t: report mismatch, expected %p, actual %p", $time, want, out_data);
            mismatches++;
          end
        end
      end
      if (start && !busy) awaited_reports.push_back(map_junction_item(in_data));
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    // map state after reset: only junction 0 at the origin, front edge to 1
    for (int k = 0; k < DEPTH; k++) begin
      pose_x[k] = '0;
      pose_y[k] = '0;
      for (int j = 0; j < 4; j++) begin
        link_ok[k][j] = 1'b0;
        link_to[k][j] = '0;
      end
    end
    link_ok[0][jgm_pkg::HEAD_FRONT] = 1'b1;
    link_to[0][jgm_pkg::HEAD_FRONT] = ID_W'(1);
    stored = 1;
    here_id = '0;
    facing = jgm_pkg::HEAD_FRONT;
    last_x = '0;
    last_y = '0;
    radius_mm = 32'(jgm_pkg::RADIUS_RST);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    feeding <= 1'b1;

    // directed part at the reset radius of 300
    pending_items.push_back(read_item(0, jgm_pkg::HEAD_FRONT)); // edge present from reset
    pending_items.push_back(read_item(1, jgm_pkg::HEAD_FRONT)); // past stored, zeros
    pending_items.push_back(read_item(63, 2'd3));
    pending_items.push_back(sense_item(300, 0, 3'b011));     // corridor, no junction
    pending_items.push_back(sense_item(0, 0, 3'b111));       // junction but still at last one
    pending_items.push_back(sense_item(32767, 32767, 3'b111));
    pending_items.push_back(turn_item(jgm_pkg::KIND_TURN_R));
    pending_items.push_back(sense_item(-32768, -32768, 3'b000));
    pending_items.push_back(turn_item(jgm_pkg::KIND_TURN_L));
    pending_items.push_back(sense_item(250, 0, 3'b010));     // repeat of junction 0
    pending_items.push_back(sense_item(-100, 0, 3'b111));    // matches the current junction
    pending_items.push_back(read_item(0, 2'd0));
    pending_items.push_back(read_item(0, 2'd2));
    pending_items.push_back(read_item(1, 2'd2));
    pending_items.push_back(read_item(2, 2'd3));
    pending_items.push_back(read_item(2, 2'd1));
    pending_items.push_back(turn_item(jgm_pkg::KIND_TURN_L));
    pending_items.push_back(turn_item(jgm_pkg::KIND_TURN_L));
    pending_items.push_back(sense_item(32767 - 299, 32767, 3'b001)); // just inside radius
    pending_items.push_back(sense_item(-32768, 32767, 3'b011));
    pending_items.push_back(sense_item(-32768, 32767, 3'b100));
    pending_items.push_back(read_item(3, 2'd0));
    pending_items.push_back(read_item(63, 2'd0));

    // random walks over several radii; radius 0 makes every junction new and fills the table
    set_radius(4095);
    queue_walk(200, 6, 1000);
    set_radius(500);
    steady = 1'b1;
    queue_walk(250, 8, 150);
    wait_quiet();
    steady = 1'b0;
    set_radius(1);
    queue_walk(200, 8, 0);
    set_radius(0);
    queue_walk(200, 8, 300);
    set_radius(2000);
    queue_walk(200, 6, 600);
    set_radius(300);
    queue_walk(250, 8, 100);

    wait_quiet();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
